### rtl/ula_pkg.sv
// ----------------------------------------------------------------------------
// ula_pkg: shared definitions for the UART line assembler
// Holds the request kinds, store sizing, sequencer states and the result type
// of the shared increment and compare unit.
// ----------------------------------------------------------------------------
package ula_pkg;

  localparam int LINE_BYTES = 32;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int UNIT_W     = 16;
  localparam int BAR_TOP    = 6;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd300;
  localparam logic [2:0]  ADDR_IDLE_TIMEOUT  = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_BAR,
    ST_TICK,
    ST_RDADDR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [UNIT_W-1:0] sum;
    logic              ge;
  } unit_res_t;

  // Thermometer pattern: the low bar bits are lit.
  function automatic logic [5:0] bar_pattern(input logic [2:0] level);
    logic [6:0] ones;
    ones = (7'd1 << level) - 7'd1;
    return ones[5:0];
  endfunction

endpackage

### rtl/ula_incr_cmp.sv
// ----------------------------------------------------------------------------
// ula_incr_cmp: shared increment and compare unit
// Adds one to operand a and compares the wrapped sum against operand b.
// ----------------------------------------------------------------------------
module ula_incr_cmp
  import ula_pkg::*;
(
  input  logic [UNIT_W-1:0] op_a,
  input  logic [UNIT_W-1:0] op_b,
  output unit_res_t         res
);

  always_comb begin
    res.sum = op_a + UNIT_W'(1);
    res.ge  = (res.sum >= op_b);
  end

endmodule

### rtl/uart_line_assembler_idle_flush.sv
// ----------------------------------------------------------------------------
// uart_line_assembler_idle_flush: line buffer with idle timeout
// Collects received bytes into a line store, closes lines on CR/LF, a full
// store or idle ticks, and reads a closed line out one byte per result.
//
//   channel  direction  fields
//   s_*      in         tuser: kind[1:0]; tdata: data_byte[7:0]
//   m_*      out        tuser: char_valid; tdata: led_bar[5:0], line_ready,
//                       char_out[7:0], zero pad; tlast: last
//   apb      in/out     idle_timeout at address 0
//
// A stored byte passes the fill and bar states before its status result is
// offered, a byte dropped at a full store the fill state only, a counted tick
// the tick state, any other request none; a take offers each line byte after
// a registered line store read addressed by the shared increment/compare unit.
// The block is not ready from acceptance until its last result is taken.
// A stalled result simply holds in the output state. Reset is synchronous.
// ----------------------------------------------------------------------------
module uart_line_assembler_idle_flush
  import ula_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // led_bar[5:0], line_ready, char_out[7:0], 0
  output logic        m_tuser,   // char_valid
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [FILL_W-1:0] fill_count;
  logic              line_waiting;
  logic              line_started;
  logic [15:0]       idle_count;
  logic [2:0]        bar_level;
  logic [15:0]       idle_timeout;
  logic [7:0]        data_reg;
  logic [FILL_W-1:0] take_count;
  logic [FILL_W-1:0] rd_idx;
  logic              rd_last;
  logic [7:0]        rd_data;
  logic              out_is_char;

  logic [7:0] line_mem [LINE_BYTES];

  logic [UNIT_W-1:0] op_a, op_b;
  unit_res_t         unit_res;

  logic in_req, out_req, cfg_wr, is_term;

  ula_incr_cmp u_unit (
    .op_a (op_a),
    .op_b (op_b),
    .res  (unit_res)
  );

  assign in_req  = s_tvalid && s_tready;
  assign out_req = m_tvalid && m_tready;
  assign is_term = (s_tdata == CH_LF) || (s_tdata == CH_CR);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_IDLE_TIMEOUT);
  assign prdata = (paddr == ADDR_IDLE_TIMEOUT) ? {16'd0, idle_timeout} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      idle_timeout <= pwdata[15:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_req) begin
          state_next = ST_OUT;
          case (s_tuser)
            KIND_BYTE: if (!line_waiting && !is_term) state_next = ST_FILL;
            KIND_TICK: if (line_started && !line_waiting) state_next = ST_TICK;
            KIND_TAKE: if (line_waiting && fill_count != '0) state_next = ST_RDADDR;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_FILL:   state_next = unit_res.ge ? ST_OUT : ST_BAR;
      ST_BAR:    state_next = ST_OUT;
      ST_TICK:   state_next = ST_OUT;
      ST_RDADDR: state_next = ST_OUT;
      ST_OUT: begin
        if (out_req) begin
          state_next = (out_is_char && !rd_last) ? ST_RDADDR : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshakes and operand selection for the shared unit.
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
    op_a     = '0;
    op_b     = '0;
    case (state)
      ST_FILL: begin
        op_a = UNIT_W'(fill_count);
        op_b = UNIT_W'(LINE_BYTES);
      end
      ST_BAR: begin
        op_a = UNIT_W'(bar_level);
        op_b = UNIT_W'(BAR_TOP + 1);
      end
      ST_TICK: begin
        op_a = idle_count;
        op_b = idle_timeout;
      end
      ST_RDADDR: begin
        op_a = UNIT_W'(rd_idx);
        op_b = UNIT_W'(take_count);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      line_waiting <= 1'b0;
      line_started <= 1'b0;
      idle_count   <= '0;
      bar_level    <= '0;
      out_is_char  <= 1'b0;
      rd_last      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_req) begin
            data_reg    <= s_tdata;
            out_is_char <= 1'b0;
            rd_idx      <= '0;
            case (s_tuser)
              KIND_BYTE: begin
                if (!line_waiting && is_term && fill_count != '0) begin
                  line_waiting <= 1'b1;
                  line_started <= 1'b0;
                  idle_count   <= '0;
                end
              end
              KIND_TAKE: begin
                if (line_waiting && fill_count != '0) begin
                  take_count   <= fill_count;
                  fill_count   <= '0;
                  line_waiting <= 1'b0;
                  line_started <= 1'b0;
                  idle_count   <= '0;
                  bar_level    <= '0;
                  out_is_char  <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL: begin
          // A byte arriving at a full store closes the line and is dropped.
          if (unit_res.ge) begin
            line_waiting <= 1'b1;
            line_started <= 1'b0;
            idle_count   <= '0;
          end else begin
            fill_count   <= unit_res.sum[FILL_W-1:0];
            idle_count   <= '0;
            line_started <= 1'b1;
          end
        end
        ST_BAR: begin
          bar_level <= unit_res.ge ? 3'd1 : unit_res.sum[2:0];
        end
        ST_TICK: begin
          if (unit_res.ge) begin
            line_waiting <= 1'b1;
            line_started <= 1'b0;
            idle_count   <= '0;
          end else begin
            idle_count <= unit_res.sum;
          end
        end
        ST_RDADDR: begin
          rd_idx  <= unit_res.sum[FILL_W-1:0];
          rd_last <= unit_res.ge;
        end
        default: begin
        end
      endcase
    end
  end

  // Line store with registered read.
  always_ff @(posedge clk) begin
    if (state == ST_FILL && !unit_res.ge) begin
      line_mem[fill_count] <= data_reg;
    end
    if (state == ST_RDADDR) begin
      rd_data <= line_mem[rd_idx];
    end
  end

  assign m_tuser = out_is_char;
  assign m_tlast = out_is_char ? rd_last : 1'b1;
  assign m_tdata = {1'b0, (out_is_char ? rd_data : 8'd0), line_waiting,
                    bar_pattern(bar_level)};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_waiting_nonempty: assert property (@(posedge clk) disable iff (rst)
    line_waiting |-> (fill_count != '0))
    else $error("closed line with an empty store");

  a_bar_range: assert property (@(posedge clk) disable iff (rst)
    bar_level <= 3'(BAR_TOP))
    else $error("bar level out of range");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (in_req && s_tuser == KIND_TAKE && line_waiting) |=>
      (fill_count == '0 && !line_waiting && bar_level == '0 && out_is_char))
    else $error("take did not clear the line state");

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (line_waiting && !(in_req && s_tuser == KIND_TAKE)) |=> line_waiting)
    else $error("waiting line dropped without a take");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UART line assembler
// Drives bytes, ticks and take requests into the stream input, predicts every
// status and line byte in a scoreboard class, and checks each output beat in
// order, under several idle timeout settings and varying back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import ula_pkg::*;

  localparam logic [1:0] KIND_NOP    = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic [5:0] led_bar;
    logic       line_ready;
    logic       char_valid;
    logic [7:0] char_out;
    logic       last;
  } beat_t;

  class line_scoreboard;
    logic [7:0]  stored [LINE_BYTES];
    int          fill;
    bit          waiting;
    bit          started;
    logic [15:0] quiet_ticks;
    logic [15:0] timeout;
    int          bar;
    beat_t       due_beats [$];
    int          failures;

    function new();
      fill        = 0;
      waiting     = 1'b0;
      started     = 1'b0;
      quiet_ticks = '0;
      timeout     = IDLE_TIMEOUT_RESET;
      bar         = 0;
      failures    = 0;
    endfunction

    function logic [5:0] bar_leds();
      logic [5:0] leds;
      for (int i = 0; i < 6; i++) leds[i] = (i < bar);
      return leds;
    endfunction

    function void close_line();
      waiting     = 1'b1;
      started     = 1'b0;
      quiet_ticks = '0;
    endfunction

    function void push_beat(logic valid, logic [7:0] ch, logic fin);
      beat_t b;
      b.led_bar    = bar_leds();
      b.line_ready = waiting;
      b.char_valid = valid;
      b.char_out   = ch;
      b.last       = fin;
      due_beats.push_back(b);
    endfunction

    // Updates the line state for one accepted request and queues its beats.
    function void absorb_request(logic [1:0] kind, logic [7:0] data);
      int n;
      if (kind == KIND_BYTE) begin
        if (!waiting) begin
          if (data == CH_LF || data == CH_CR) begin
            if (fill > 0) close_line();
          end else if (fill < LINE_BYTES - 1) begin
            stored[fill] = data;
            fill++;
            quiet_ticks = '0;
            started = 1'b1;
            bar++;
            if (bar > BAR_TOP) bar = 1;
          end else begin
            // A byte arriving at a full store closes the line and is lost.
            close_line();
          end
        end
      end else if (kind == KIND_TICK) begin
        if (started && !waiting) begin
          quiet_ticks = quiet_ticks + 16'd1;
          if (quiet_ticks >= timeout) close_line();
        end
      end else if (kind == KIND_TAKE && waiting && fill > 0) begin
        n = fill;
        fill = 0;
        waiting = 1'b0;
        started = 1'b0;
        quiet_ticks = '0;
        bar = 0;
        for (int i = 0; i < n; i++) push_beat(1'b1, stored[i], i == n - 1);
        return;
      end
      push_beat(1'b0, 8'h00, 1'b1);
    endfunction

    function bit field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        failures++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_beat(logic [15:0] tdata, logic tuser, logic tlast);
      beat_t want;
      bit    ok;
      if (due_beats.size() == 0) begin
        $display("%0t mismatch beat: expected none, actual %0h/%0b/%0b",
                 $time, tdata, tuser, tlast);
        failures++;
        return;
      end
      want = due_beats.pop_front();
      ok = field_ok("led_bar", want.led_bar, tdata[5:0]);
      ok = field_ok("line_ready", want.line_ready, tdata[6]);
      ok = field_ok("char_valid", want.char_valid, tuser);
      ok = field_ok("char_out", want.char_out, tdata[14:7]);
      ok = field_ok("last", want.last, tlast);
    endfunction

    function void flag_leftovers();
      if (due_beats.size() != 0) begin
        $display("%0t mismatch beat count: expected %0d more, actual 0",
                 $time, due_beats.size());
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = KIND_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = ADDR_IDLE_TIMEOUT;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  line_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int quiet_cycles = 0;

  uart_line_assembler_idle_flush u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.match_beat(m_tdata, m_tuser, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid === 1'b1 && s_tready === 1'b1) ||
        (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.absorb_request(kind, data);
    sent_count++;
  endtask

  // Optionally writes the idle timeout, then reads it back.
  task automatic program_idle_timeout(input bit do_write, input logic [15:0] value);
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_IDLE_TIMEOUT;
      pwdata  <= {16'h0, value};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      sb.timeout = value;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_IDLE_TIMEOUT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0, sb.timeout}) begin
      $display("%0t mismatch idle_timeout: expected %0h, actual %0h",
               $time, sb.timeout, prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
  endtask

  // Runs with a zero idle timeout, so any tick closes a started line.
  task automatic run_directed();
    send_request(KIND_TAKE, 8'h00);
    send_request(KIND_TICK, 8'hFF);
    send_request(KIND_BYTE, CH_LF);
    send_request(KIND_BYTE, CH_CR);
    send_request(KIND_NOP, 8'h00);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_BYTE, 8'hFF);
    send_request(KIND_TICK, 8'h00);
    send_request(KIND_BYTE, 8'h41);
    send_request(KIND_TICK, 8'h00);
    send_request(KIND_TAKE, 8'h00);
    send_request(KIND_TAKE, 8'hFF);
    send_request(KIND_BYTE, 8'h80);
    send_request(KIND_BYTE, 8'h7F);
    send_request(KIND_BYTE, 8'h01);
    send_request(KIND_BYTE, 8'hFE);
    send_request(KIND_BYTE, 8'h55);
    send_request(KIND_BYTE, 8'hAA);
    send_request(KIND_BYTE, 8'h20);
    send_request(KIND_BYTE, CH_CR);
    send_request(KIND_BYTE, CH_LF);
    send_request(KIND_NOP, 8'hFF);
    send_request(KIND_TAKE, 8'h00);
  endtask

  // One burst: mostly a line of random bytes, a way to close it and a take.
  task automatic random_episode();
    int n;
    int mode;
    int closer;
    if ($urandom_range(9) == 0) begin
      mode = $urandom_range(1, 4);
      repeat (mode) send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    n = ($urandom_range(7) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 8);
    repeat (n) send_request(KIND_BYTE, 8'($urandom_range(255)));
    closer = $urandom_range(4);
    case (closer)
      0: send_request(KIND_BYTE, CH_CR);
      1: send_request(KIND_BYTE, CH_LF);
      2: begin
        send_request(KIND_BYTE, CH_CR);
        send_request(KIND_BYTE, CH_LF);
      end
      3: begin
        if (sb.timeout <= 8) repeat (sb.timeout + $urandom_range(1)) send_request(KIND_TICK, 8'h00);
        else repeat ($urandom_range(1, 4)) send_request(KIND_TICK, 8'h00);
      end
      default: ;
    endcase
    if ($urandom_range(3) == 0) send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
    if ($urandom_range(5) != 0) send_request(KIND_TAKE, 8'($urandom_range(255)));
    if ($urandom_range(7) == 0) send_request(KIND_TAKE, 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int target);
    int start;
    start = sent_count;
    while (sent_count - start < target) random_episode();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 62;
    program_idle_timeout(1'b0, 16'h0);
    @(posedge clk);
    program_idle_timeout(1'b1, 16'd0);
    run_directed();
    settle();
    program_idle_timeout(1'b1, 16'd5);
    run_random(ITEMS_PER_PHASE);
    settle();
    send_idle_pct = 62;
    recv_idle_pct = 14;
    program_idle_timeout(1'b1, 16'hFFFF);
    run_random(ITEMS_PER_PHASE);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_idle_timeout(1'b1, 16'd1);
    run_random(ITEMS_PER_PHASE);
    settle();
    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### uart_line_assembler_idle_flush.f
rtl/ula_pkg.sv
rtl/ula_incr_cmp.sv
rtl/uart_line_assembler_idle_flush.sv
bench/tb_top.sv
